>>> design/ssf_pkg.sv
// Shared types and codes for the shortest-seek-first scheduler.
package ssf_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int SECTOR_BITS_DEF = 48;

  localparam int SECTOR_FIELD_W = 48;
  localparam int COUNT_FIELD_W  = 6;

  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam logic [1:0] STATUS_ADDED      = 2'd0;
  localparam logic [1:0] STATUS_DISPATCHED = 2'd1;
  localparam logic [1:0] STATUS_EMPTY      = 2'd2;
  localparam logic [1:0] STATUS_FULL       = 2'd3;

  typedef struct packed {
    logic wr;
    logic shift;
  } ssf_cell_ctrl_t;

endpackage

>>> design/ssf_cell.sv
// One table entry with its slice of the nearest-sector search wave.
module ssf_cell #(
  parameter int SECTOR_BITS = ssf_pkg::SECTOR_BITS_DEF,
  parameter int IDX_W       = 5,
  parameter int CNT_W       = 6,
  parameter int INDEX       = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ssf_pkg::ssf_cell_ctrl_t    ctrl,
  input  logic [SECTOR_BITS-1:0]     wr_sector,
  input  logic [CNT_W-1:0]           count,
  input  logic [SECTOR_BITS-1:0]     head,
  input  logic [IDX_W-1:0]           shift_idx,
  input  logic [SECTOR_BITS-1:0]     nbr_sector,
  output logic [SECTOR_BITS-1:0]     sector,
  input  logic                       wave_valid_in,
  input  logic [SECTOR_BITS-1:0]     wave_dist_in,
  input  logic [SECTOR_BITS-1:0]     wave_sector_in,
  input  logic [IDX_W-1:0]           wave_idx_in,
  output logic                       wave_valid_out,
  output logic [SECTOR_BITS-1:0]     wave_dist_out,
  output logic [SECTOR_BITS-1:0]     wave_sector_out,
  output logic [IDX_W-1:0]           wave_idx_out
);
  import ssf_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

  logic [SECTOR_BITS-1:0] sector_r, sector_nxt;
  logic                   valid_r;
  logic [SECTOR_BITS-1:0] dist_r;
  logic [SECTOR_BITS-1:0] best_sector_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   occupied;
  logic [SECTOR_BITS-1:0] seek_dist;
  logic                   take;

  assign occupied  = (MY_CNT < count);
  assign seek_dist = (sector_r >= head) ? (sector_r - head) : (head - sector_r);
  // strict compare keeps the earlier arrival on a tie
  assign take      = occupied && (!wave_valid_in || (seek_dist < wave_dist_in));

  always_comb begin
    sector_nxt = sector_r;
    if (ctrl.wr && (count == MY_CNT)) begin
      sector_nxt = wr_sector;
    end else if (ctrl.shift && (shift_idx <= MY_IDX)) begin
      sector_nxt = nbr_sector;
    end
  end

  always_ff @(posedge clk) begin
    sector_r <= sector_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= wave_valid_in | occupied;
    end
    if (take) begin
      dist_r        <= seek_dist;
      best_sector_r <= sector_r;
      idx_r         <= MY_IDX;
    end else begin
      dist_r        <= wave_dist_in;
      best_sector_r <= wave_sector_in;
      idx_r         <= wave_idx_in;
    end
  end

  assign sector          = sector_r;
  assign wave_valid_out  = valid_r;
  assign wave_dist_out   = dist_r;
  assign wave_sector_out = best_sector_r;
  assign wave_idx_out    = idx_r;

endmodule

>>> design/shortest_seek_first_scheduler.sv
// Shortest-seek-first scheduler: control, head position and the row of entry cells.
// Add, rejected add and empty dispatch: result strobe in the cycle after the transfer; busy stays low.
// Dispatch on a non-empty table: busy through the SCAN and SHIFT states, result strobe in the next cycle.
// The dispatch time is set by the search wave, which advances one cell of the row per cycle.
// Reset (rst_n low, synchronous) empties the table, clears the head position and drops any result.
// Results are shown for one cycle only; the receiver cannot stall the block.
module shortest_seek_first_scheduler #(
  parameter int QUEUE_DEPTH = ssf_pkg::QUEUE_DEPTH_DEF,
  parameter int SECTOR_BITS = ssf_pkg::SECTOR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_opcode,
  input  logic [ssf_pkg::SECTOR_FIELD_W-1:0]  in_request_sector,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [ssf_pkg::SECTOR_FIELD_W-1:0]  out_dispatched_sector,
  output logic [ssf_pkg::COUNT_FIELD_W-1:0]   out_pending_count
);
  import ssf_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [IDX_W-1:0]       scan_cnt_r, scan_cnt_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [SECTOR_BITS-1:0] head_r, head_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [1:0]                out_status_r, out_status_nxt;
  logic [SECTOR_FIELD_W-1:0] out_sector_r, out_sector_nxt;
  logic [COUNT_FIELD_W-1:0]  out_count_r;
  logic [COUNT_FIELD_W-1:0]  count_field;

  logic                   accept;
  logic                   full;
  logic [SECTOR_BITS-1:0] req_sector;
  logic [SECTOR_FIELD_W-1:0] best_field;
  ssf_cell_ctrl_t         cell_ctrl;

  logic [SECTOR_BITS-1:0] cell_sector [QUEUE_DEPTH];
  logic                   wave_valid  [QUEUE_DEPTH];
  logic [SECTOR_BITS-1:0] wave_dist   [QUEUE_DEPTH];
  logic [SECTOR_BITS-1:0] wave_sector [QUEUE_DEPTH];
  logic [IDX_W-1:0]       wave_idx    [QUEUE_DEPTH];

  // Hold off transfers during reset as well as while a dispatch is at work.
  assign busy   = (state_r != ST_IDLE) || !rst_n;
  assign accept = start && !busy;
  assign full   = (count_r == FULL_CNT);

  // Fit the request field to the kept sector width, and the result back to the field.
  generate
    if (SECTOR_BITS >= SECTOR_FIELD_W) begin : g_wide
      assign req_sector = SECTOR_BITS'(in_request_sector);
      assign best_field = wave_sector[QUEUE_DEPTH-1][SECTOR_FIELD_W-1:0];
    end else begin : g_narrow
      assign req_sector = in_request_sector[SECTOR_BITS-1:0];
      assign best_field = {{(SECTOR_FIELD_W - SECTOR_BITS){1'b0}},
                           wave_sector[QUEUE_DEPTH-1]};
    end
    if (CNT_W >= COUNT_FIELD_W) begin : g_cnt_wide
      assign count_field = count_nxt[COUNT_FIELD_W-1:0];
    end else begin : g_cnt_narrow
      assign count_field = {{(COUNT_FIELD_W - CNT_W){1'b0}}, count_nxt};
    end
  endgenerate

  assign cell_ctrl.wr    = accept && (in_opcode == OP_ADD) && !full;
  assign cell_ctrl.shift = (state_r == ST_SHIFT);

  always_comb begin
    state_nxt      = state_r;
    scan_cnt_nxt   = scan_cnt_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_sector_nxt = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_ADD) begin
            out_valid_nxt = 1'b1;
            if (full) begin
              out_status_nxt = STATUS_FULL;
            end else begin
              out_status_nxt = STATUS_ADDED;
              count_nxt      = count_r + CNT_W'(1);
            end
          end else if (count_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_EMPTY;
          end else begin
            // start the search wave down the row
            state_nxt    = ST_SCAN;
            scan_cnt_nxt = '0;
          end
        end
      end
      ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + IDX_W'(1);
        // the last cell's wave register is settled at the edge that ends this count
        if (scan_cnt_r == LAST_IDX) begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        // drop the chosen entry, close the gap, advance the head
        state_nxt      = ST_IDLE;
        count_nxt      = count_r - CNT_W'(1);
        head_nxt       = wave_sector[QUEUE_DEPTH-1];
        out_valid_nxt  = 1'b1;
        out_status_nxt = STATUS_DISPATCHED;
        out_sector_nxt = best_field;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_cnt_r   <= scan_cnt_nxt;
    out_status_r <= out_status_nxt;
    out_sector_r <= out_sector_nxt;
    out_count_r  <= count_field;
  end

  // Row of entry cells, arrival order by position; the search wave runs from cell zero.
  generate
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                   w_valid;
      logic [SECTOR_BITS-1:0] w_dist;
      logic [SECTOR_BITS-1:0] w_sector;
      logic [IDX_W-1:0]       w_idx;
      logic [SECTOR_BITS-1:0] nbr;

      if (i == 0) begin : g_first
        assign w_valid  = 1'b0;
        assign w_dist   = '0;
        assign w_sector = '0;
        assign w_idx    = '0;
      end else begin : g_rest
        assign w_valid  = wave_valid[i-1];
        assign w_dist   = wave_dist[i-1];
        assign w_sector = wave_sector[i-1];
        assign w_idx    = wave_idx[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign nbr = cell_sector[i];
      end else begin : g_inner
        assign nbr = cell_sector[i+1];
      end

      ssf_cell #(
        .SECTOR_BITS (SECTOR_BITS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W),
        .INDEX       (i)
      ) u_cell (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (cell_ctrl),
        .wr_sector       (req_sector),
        .count           (count_r),
        .head            (head_r),
        .shift_idx       (wave_idx[QUEUE_DEPTH-1]),
        .nbr_sector      (nbr),
        .sector          (cell_sector[i]),
        .wave_valid_in   (w_valid),
        .wave_dist_in    (w_dist),
        .wave_sector_in  (w_sector),
        .wave_idx_in     (w_idx),
        .wave_valid_out  (wave_valid[i]),
        .wave_dist_out   (wave_dist[i]),
        .wave_sector_out (wave_sector[i]),
        .wave_idx_out    (wave_idx[i])
      );
    end
  endgenerate

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_dispatched_sector = out_sector_r;
  assign out_pending_count     = out_count_r;

`ifndef SYNTH
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while a dispatch is at work");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("pending count beyond table depth");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (count_r != '0))
    else $error("search wave running on an empty table");

  a_dispatch_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STATUS_DISPATCHED)) |-> ($past(state_r) == ST_SHIFT))
    else $error("dispatch result without a completed search");

  a_head_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |=> (head_r == $past(wave_sector[QUEUE_DEPTH-1])))
    else $error("head position not taken from the chosen entry");

  a_shift_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pending count not reduced on dispatch");
`endif

endmodule

>>> bench/shortest_seek_first_scheduler_tb.sv
// Self-checking bench for the shortest-seek-first scheduler: random add/dispatch traffic.
module shortest_seek_first_scheduler_tb;
  import ssf_pkg::*;

  localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
  localparam int ITEM_TOTAL  = 1850;
  localparam logic [SECTOR_FIELD_W-1:0] SECTOR_MAX = '1;

  // One request as the sender presents it.
  typedef struct packed {
    logic                      op;
    logic [SECTOR_FIELD_W-1:0] sector;
  } sched_cmd_t;

  // One result as the block reports it.
  typedef struct packed {
    logic [1:0]                status;
    logic [SECTOR_FIELD_W-1:0] sector;
    logic [COUNT_FIELD_W-1:0]  count;
  } sched_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_opcode;
  logic [SECTOR_FIELD_W-1:0] in_request_sector;
  logic                      out_valid;
  logic [1:0]                out_status;
  logic [SECTOR_FIELD_W-1:0] out_dispatched_sector;
  logic [COUNT_FIELD_W-1:0]  out_pending_count;

  shortest_seek_first_scheduler dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_opcode             (in_opcode),
    .in_request_sector     (in_request_sector),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_dispatched_sector (out_dispatched_sector),
    .out_pending_count     (out_pending_count)
  );

  always #5 clk = ~clk;

  // Requests waiting to be offered, and results the scheduler owes us, oldest first.
  sched_cmd_t    request_backlog[$];
  sched_result_t predicted_results[$];

  // Shadow of the scheduler: pending sectors in arrival order and the head position.
  logic [SECTOR_FIELD_W-1:0] shadow_pending[$];
  logic [SECTOR_FIELD_W-1:0] shadow_head;

  // Stimulus shaping: a cluster centre for near-equal sectors and a short history for repeats.
  logic [SECTOR_FIELD_W-1:0] cluster_base;
  logic [SECTOR_FIELD_W-1:0] recent_sectors[$];

  int status_tally[4];
  int seek_ties;
  int fail_count;
  bit in_taken;
  int burst_left;
  int idle_left;
  sched_cmd_t next_cmd;

  function automatic logic [SECTOR_FIELD_W-1:0] seek_gap(logic [SECTOR_FIELD_W-1:0] a,
                                                          logic [SECTOR_FIELD_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Apply one accepted request to the shadow and return the result it must produce.
  function automatic sched_result_t predict_schedule(logic op, logic [SECTOR_FIELD_W-1:0] sector);
    sched_result_t             res;
    int                        best_idx;
    logic [SECTOR_FIELD_W-1:0] best_gap;
    logic [SECTOR_FIELD_W-1:0] gap;
    res = '0;
    if (op == OP_ADD) begin
      if (shadow_pending.size() >= QUEUE_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        shadow_pending.push_back(sector);
        res.status = STATUS_ADDED;
      end
    end else if (shadow_pending.size() == 0) begin
      // Empty dispatch: head position stays where it was.
      res.status = STATUS_EMPTY;
    end else begin
      // True minimum from the first entry; later entries must be strictly nearer to win.
      best_idx = 0;
      best_gap = seek_gap(shadow_pending[0], shadow_head);
      for (int i = 1; i < shadow_pending.size(); i++) begin
        gap = seek_gap(shadow_pending[i], shadow_head);
        if (gap < best_gap) begin
          best_gap = gap;
          best_idx = i;
        end else if (gap == best_gap) begin
          seek_ties++;
        end
      end
      res.sector  = shadow_pending[best_idx];
      shadow_head = res.sector;
      shadow_pending.delete(best_idx);
      res.status  = STATUS_DISPATCHED;
    end
    res.count = COUNT_FIELD_W'(shadow_pending.size());
    status_tally[res.status]++;
    return res;
  endfunction

  // Draw a sector: wide random, clustered (for equal distances), extremes, single bits, repeats.
  function automatic logic [SECTOR_FIELD_W-1:0] random_sector();
    logic [SECTOR_FIELD_W-1:0] s;
    case ($urandom_range(0, 9))
      0, 1, 2: s = {16'($urandom), 32'($urandom)};
      3, 4, 5: s = cluster_base + SECTOR_FIELD_W'($urandom_range(0, 31));
      6:       s = $urandom_range(0, 1) ? SECTOR_MAX : '0;
      7:       s = SECTOR_FIELD_W'(1) << $urandom_range(0, SECTOR_FIELD_W - 1);
      default: s = (recent_sectors.size() != 0) ?
                   recent_sectors[$urandom_range(0, recent_sectors.size() - 1)] :
                   cluster_base;
    endcase
    recent_sectors.push_back(s);
    if (recent_sectors.size() > 16) void'(recent_sectors.pop_front());
    return s;
  endfunction

  task automatic queue_request(logic op, logic [SECTOR_FIELD_W-1:0] sector);
    sched_cmd_t c;
    c.op     = op;
    c.sector = sector;
    request_backlog.push_back(c);
  endtask

  // Report the first ten faults in full, count the rest.
  task automatic note_fault(string what, sched_result_t want);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: expected status %0d sector %h count %0d, got status %0d sector %h count %0d",
               $realtime, what, want.status, want.sector, want.count,
               out_status, out_dispatched_sector, out_pending_count);
  endtask

  // Driver: offer requests at the falling edge, in bursts separated by idle gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !in_taken) begin
      // hold the request until the scheduler takes it
    end else if (idle_left != 0) begin
      start <= 1'b0;
      idle_left--;
    end else if (request_backlog.size() != 0) begin
      next_cmd = request_backlog.pop_front();
      start             <= 1'b1;
      in_opcode         <= next_cmd.op;
      in_request_sector <= next_cmd.sector;
      if (burst_left <= 1) begin
        // start a fresh burst; a quarter of bursts run straight on with no gap
        burst_left = $urandom_range(1, 24);
        case ($urandom_range(0, 7))
          0, 1:    idle_left = 0;
          2:       idle_left = $urandom_range(7, 40);
          default: idle_left = $urandom_range(1, 6);
        endcase
      end else begin
        burst_left--;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: at the rising edge, check any result strobe, then log a request transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      if (out_valid) begin
        if (predicted_results.size() == 0) begin
          note_fault("result with nothing outstanding", '0);
        end else if (predicted_results[0] !=
                     {out_status, out_dispatched_sector, out_pending_count}) begin
          note_fault("result mismatch", predicted_results.pop_front());
        end else begin
          void'(predicted_results.pop_front());
        end
      end
      in_taken = start && !busy;
      if (in_taken)
        predicted_results.push_back(predict_schedule(in_opcode, in_request_sector));
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("Run timed out with %0d requests unsent and %0d results outstanding",
             request_backlog.size(), predicted_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int add_pct;
    int phase_len;

    rst_n             = 1'b0;
    start             = 1'b0;
    in_opcode         = OP_ADD;
    in_request_sector = '0;
    shadow_head       = '0;
    cluster_base      = '0;
    burst_left        = 0;
    idle_left         = 0;
    seek_ties         = 0;
    fail_count        = 0;
    status_tally      = '{default: 0};

    // Directed opening: empty dispatch, extreme sectors, far seeks and tie breaks.
    queue_request(OP_DISPATCH, SECTOR_MAX);      // nothing pending
    queue_request(OP_ADD, '0);
    queue_request(OP_ADD, SECTOR_MAX);
    queue_request(OP_DISPATCH, '0);              // zero distance from reset head
    queue_request(OP_DISPATCH, '0);              // largest possible distance still picked
    queue_request(OP_DISPATCH, '0);              // empty again, head must stay at the top
    queue_request(OP_ADD, '0);
    queue_request(OP_ADD, 48'h8000_0000_0000);
    queue_request(OP_DISPATCH, '0);
    queue_request(OP_DISPATCH, '0);
    queue_request(OP_ADD, 48'd100);
    queue_request(OP_DISPATCH, '0);              // head moves to 100
    queue_request(OP_ADD, 48'd110);
    queue_request(OP_ADD, 48'd90);
    queue_request(OP_ADD, 48'd90);
    queue_request(OP_DISPATCH, '0);              // 110 and 90 tie, earlier arrival wins
    queue_request(OP_ADD, 48'd130);
    queue_request(OP_DISPATCH, '0);              // two 90s tie with 130, first 90 wins
    queue_request(OP_DISPATCH, '0);
    queue_request(OP_DISPATCH, '0);
    queue_request(OP_ADD, 48'h5555_5555_5555);
    queue_request(OP_ADD, 48'hAAAA_AAAA_AAAA);
    queue_request(OP_DISPATCH, SECTOR_MAX);
    queue_request(OP_DISPATCH, 48'h5555_5555_5555);

    // Random phases: add-heavy phases fill the table past full, drain phases run it dry.
    while (request_backlog.size() < ITEM_TOTAL) begin
      case ($urandom_range(0, 4))
        0:       add_pct = 92;
        1:       add_pct = 65;
        2:       add_pct = 50;
        3:       add_pct = 35;
        default: add_pct = 8;
      endcase
      case ($urandom_range(0, 3))
        0:       cluster_base = '0;
        1:       cluster_base = SECTOR_MAX - 40;
        default: cluster_base = {16'($urandom), 32'($urandom)};
      endcase
      phase_len = $urandom_range(10, 90);
      repeat (phase_len)
        queue_request(($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_DISPATCH, random_sector());
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every request to be taken, every result to land, then a quiet tail.
    while (request_backlog.size() != 0 || start) @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (QUEUE_DEPTH + 8) @(posedge clk);
    fail_count += predicted_results.size();

    $display("Covered %0d adds, %0d rejected on a full table, %0d dispatches, %0d on empty",
             status_tally[STATUS_ADDED], status_tally[STATUS_FULL],
             status_tally[STATUS_DISPATCHED], status_tally[STATUS_EMPTY]);
    $display("Seek ties resolved by arrival order: %0d; faults: %0d", seek_ties, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
